### hdl/fvt_pkg.sv
package fvt_pkg;

  localparam int PlaneCount  = 6;
  localparam int CornerCount = 8;
  localparam int PlaneW      = 64;
  localparam int CoordW      = 16;
  localparam int ExtW        = 15;
  localparam int FracBits    = 14;
  // Product of a Q1.14 normal and a Q11.4 coordinate or half size.
  localparam int ProdW       = 32;
  // Six products of up to 2^30 and d scaled by 2^14 stay below 2^33.
  localparam int SumW        = 35;
  localparam int AddrW       = 6;
  localparam int IdxW        = 3;

  typedef enum logic [1:0] {
    KIND_POINT  = 2'd0,
    KIND_SPHERE = 2'd1,
    KIND_CUBE   = 2'd2
  } fvt_kind_e;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic [ExtW-1:0]          ext;
  } fvt_item_t;

  // Running verdict of an item as it walks down the row of plane cells.
  typedef struct packed {
    logic                   cen_ok;
    logic [CornerCount-1:0] corner_ok;
  } fvt_flags_t;

  typedef logic [PlaneCount-1:0][PlaneW-1:0] fvt_planes_t;

endpackage

### hdl/fvt_regs.sv
module fvt_regs import fvt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [PlaneW-1:0]   pwdata,
  output logic [PlaneW-1:0]   prdata,
  output logic                pready,
  output fvt_planes_t         planes_o
);

  fvt_planes_t     planes_q;
  logic [IdxW-1:0] idx;
  logic            idx_ok;
  logic            wr_en;

  assign idx    = paddr[AddrW-1:AddrW-IdxW];
  assign idx_ok = idx < IdxW'(PlaneCount);
  assign wr_en  = psel && penable && pwrite && idx_ok;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      planes_q <= '0;
    end else if (wr_en) begin
      planes_q[idx] <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (idx_ok) begin
      prdata = planes_q[idx];
    end
  end

  assign planes_o = planes_q;

endmodule

### hdl/fvt_cell.sv
module fvt_cell import fvt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [PlaneW-1:0] plane_i,
  input  logic              valid_i,
  input  fvt_item_t         item_i,
  input  fvt_flags_t        flags_i,
  output logic              valid_o,
  output fvt_item_t         item_o,
  output fvt_flags_t        flags_o
);

  logic signed [CoordW-1:0] nx, ny, nz, dd;

  // Multiply rank.
  logic                    va_q;
  fvt_item_t               itema_q;
  fvt_flags_t              flagsa_q;
  logic signed [ProdW-1:0] px_q, py_q, pz_q, hx_q, hy_q, hz_q;
  logic signed [CoordW-1:0] da_q;

  // Sum rank.
  logic                   vb_q;
  fvt_item_t              itemb_q;
  fvt_flags_t             flagsb_q;
  logic signed [SumW-1:0] s_q;
  logic signed [SumW-1:0] hxb_q;
  logic signed [SumW-1:0] yz_q [4];
  logic signed [SumW-1:0] yz_d [4];

  // Compare rank.
  logic                   vc_q;
  fvt_item_t              itemc_q;
  fvt_flags_t             flagsc_q;
  fvt_flags_t             flagsc_d;
  logic signed [SumW-1:0] corner_sum [CornerCount];
  logic signed [SumW-1:0] rad;
  logic signed [SumW-1:0] hx_term;

  assign nx = plane_i[15:0];
  assign ny = plane_i[31:16];
  assign nz = plane_i[47:32];
  assign dd = plane_i[63:48];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  // Corner sums are split as n.c + d plus signed half-size terms per axis.
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      yz_d[j] = (j[0] ? SumW'(hy_q) : -SumW'(hy_q))
              + (j[1] ? SumW'(hz_q) : -SumW'(hz_q));
    end
  end

  always_comb begin
    rad      = $signed(SumW'(itemb_q.ext) << FracBits);
    flagsc_d = flagsb_q;
    for (int i = 0; i < CornerCount; i++) begin
      hx_term       = i[0] ? hxb_q : -hxb_q;
      corner_sum[i] = s_q + hx_term + yz_q[i[2:1]];
      flagsc_d.corner_ok[i] = flagsb_q.corner_ok[i] && (corner_sum[i] > 0);
    end
    if (itemb_q.kind == KIND_SPHERE) begin
      flagsc_d.cen_ok = flagsb_q.cen_ok && (s_q + rad >= 0);
    end else begin
      flagsc_d.cen_ok = flagsb_q.cen_ok && (s_q > 0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      itema_q  <= item_i;
      flagsa_q <= flags_i;
      px_q     <= ProdW'(nx) * ProdW'(item_i.x);
      py_q     <= ProdW'(ny) * ProdW'(item_i.y);
      pz_q     <= ProdW'(nz) * ProdW'(item_i.z);
      hx_q     <= ProdW'(nx) * ProdW'($signed({1'b0, item_i.ext}));
      hy_q     <= ProdW'(ny) * ProdW'($signed({1'b0, item_i.ext}));
      hz_q     <= ProdW'(nz) * ProdW'($signed({1'b0, item_i.ext}));
      da_q     <= dd;

      itemb_q  <= itema_q;
      flagsb_q <= flagsa_q;
      s_q      <= SumW'(px_q) + SumW'(py_q) + SumW'(pz_q) + (SumW'(da_q) <<< FracBits);
      hxb_q    <= SumW'(hx_q);
      for (int j = 0; j < 4; j++) begin
        yz_q[j] <= yz_d[j];
      end

      itemc_q  <= itemb_q;
      flagsc_q <= flagsc_d;
    end
  end

  assign valid_o = vc_q;
  assign item_o  = itemc_q;
  assign flags_o = flagsc_q;

endmodule

### hdl/frustum_visibility_test_unit.sv
// Channel   | valid       | stall       | payload
// ----------+-------------+-------------+------------------------------------------
// input     | in_valid_i  | in_stall_o  | kind_i, pos_x_i, pos_y_i, pos_z_i, extent_i
// output    | out_valid_o | out_stall_i | visible_o
// config    | APB write at psel, penable, pwrite; 64-bit plane at byte address 8*i
//
// One item is taken every cycle while the result is not stalled; the six plane
// cells of three ranks each plus the output register lie between input and result.
// Reset clears the plane registers to zero and empties the cell row.
// A stalled result freezes the whole row, and in_stall_o follows it in the
// same cycle; otherwise the row moves every cycle.
module frustum_visibility_test_unit import fvt_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [AddrW-1:0]         paddr,
  input  logic [PlaneW-1:0]        pwdata,
  output logic [PlaneW-1:0]        prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               kind_i,
  input  logic signed [CoordW-1:0] pos_x_i,
  input  logic signed [CoordW-1:0] pos_y_i,
  input  logic signed [CoordW-1:0] pos_z_i,
  input  logic [ExtW-1:0]          extent_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     visible_o
);

  fvt_planes_t planes;
  logic        en;
  logic        out_valid_q;
  logic        visible_q;
  logic        visible_d;

  logic        valid_c [PlaneCount+1];
  fvt_item_t   item_c  [PlaneCount+1];
  fvt_flags_t  flags_c [PlaneCount+1];

  fvt_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .planes_o (planes)
  );

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  assign valid_c[0]       = in_valid_i;
  assign item_c[0].kind   = kind_i;
  assign item_c[0].x      = pos_x_i;
  assign item_c[0].y      = pos_y_i;
  assign item_c[0].z      = pos_z_i;
  assign item_c[0].ext    = extent_i;
  assign flags_c[0]       = '1;

  for (genvar k = 0; k < PlaneCount; k++) begin : g_cell
    fvt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .plane_i (planes[k]),
      .valid_i (valid_c[k]),
      .item_i  (item_c[k]),
      .flags_i (flags_c[k]),
      .valid_o (valid_c[k+1]),
      .item_o  (item_c[k+1]),
      .flags_o (flags_c[k+1])
    );
  end

  always_comb begin
    unique case (item_c[PlaneCount].kind)
      KIND_POINT, KIND_SPHERE: visible_d = flags_c[PlaneCount].cen_ok;
      KIND_CUBE:               visible_d = |flags_c[PlaneCount].corner_ok;
      default:                 visible_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= valid_c[PlaneCount];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      visible_q <= visible_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign visible_o   = visible_q;

endmodule

### hdl/fvt_checker.sv
module fvt_checker import fvt_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     psel,
  input logic                     penable,
  input logic                     pwrite,
  input logic [AddrW-1:0]         paddr,
  input logic [PlaneW-1:0]        pwdata,
  input logic [PlaneW-1:0]        prdata,
  input logic                     pready,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic                     visible_o
);

  // The row comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

  // A held result keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(visible_o))
    else $error("stalled result changed");

  // The input side only waits on a stalled result.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  // A plane written and then read at once returns the written word.
  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready &&
     paddr[AddrW-1:AddrW-IdxW] < IdxW'(PlaneCount))
    ##1 (psel && !pwrite && paddr == $past(paddr))
    |-> prdata == $past(pwdata))
    else $error("plane register readback mismatch");

endmodule

bind frustum_visibility_test_unit fvt_checker u_fvt_checker (.*);

### bench/tb.sv
module tb;
  import fvt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Register indexes of the plane set; the two spare slots decode to nothing.
  localparam int RegNear   = 0;
  localparam int RegFar    = 1;
  localparam int RegLeft   = 2;
  localparam int RegRight  = 3;
  localparam int RegTop    = 4;
  localparam int RegBottom = 5;
  localparam int RegSpareA = 6;
  localparam int RegSpareB = 7;

  localparam logic [1:0] KindUnused = 2'd3;

  localparam int RandPhases    = 9;
  localparam int ItemsPerPhase = 134;
  localparam int LongHold      = 300;
  localparam int SettleCycles  = 24;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     psel        = 1'b0;
  logic                     penable     = 1'b0;
  logic                     pwrite      = 1'b0;
  logic [AddrW-1:0]         paddr       = '0;
  logic [PlaneW-1:0]        pwdata      = '0;
  logic [PlaneW-1:0]        prdata;
  logic                     pready;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  logic [1:0]               kind_i      = '0;
  logic signed [CoordW-1:0] pos_x_i     = '0;
  logic signed [CoordW-1:0] pos_y_i     = '0;
  logic signed [CoordW-1:0] pos_z_i     = '0;
  logic [ExtW-1:0]          extent_i    = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic                     visible_o;

  frustum_visibility_test_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .pos_z_i    (pos_z_i),
    .extent_i   (extent_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .visible_o  (visible_o)
  );

  logic [PlaneW-1:0] plane_reg [PlaneCount];
  fvt_item_t         pending_items [$];
  logic              visible_due [$];
  fvt_item_t         next_item;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  bit                hold_armed    = 1'b0;
  bit                hold_used     = 1'b0;
  int                hold_left     = 0;
  int                fail_count    = 0;

  // ---------------------------------------------------------------- predictor

  // n.p + d of plane k with 18 fraction bits.
  function automatic longint plane_dist(int k, longint px, longint py, longint pz);
    logic signed [15:0] nx, ny, nz, d;
    {d, nz, ny, nx} = plane_reg[k];
    return nx * px + ny * py + nz * pz + (longint'(d) <<< FracBits);
  endfunction

  function automatic bit point_in_frustum(longint px, longint py, longint pz);
    for (int k = 0; k < PlaneCount; k++) begin
      if (plane_dist(k, px, py, pz) <= 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic shape_visible(fvt_item_t it);
    longint px, py, pz, e, lim, cx, cy, cz;
    bit     vis;
    px  = it.x;
    py  = it.y;
    pz  = it.z;
    e   = longint'(it.ext);
    vis = 1'b0;
    case (it.kind)
      KIND_POINT: vis = point_in_frustum(px, py, pz);
      KIND_SPHERE: begin
        lim = -(e <<< FracBits);
        vis = 1'b1;
        for (int k = 0; k < PlaneCount; k++) begin
          if (plane_dist(k, px, py, pz) < lim) vis = 1'b0;
        end
      end
      KIND_CUBE: begin
        for (int c = 0; c < CornerCount; c++) begin
          cx = c[0] ? px + e : px - e;
          cy = c[2] ? py + e : py - e;
          cz = c[1] ? pz + e : pz - e;
          if (point_in_frustum(cx, cy, cz)) vis = 1'b1;
        end
      end
      default: vis = 1'b0;
    endcase
    return vis;
  endfunction

  // ------------------------------------------------------------ driver, monitor

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        visible_due.push_back(shape_visible(next_item));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item  <= pending_items[0];
          kind_i     <= pending_items[0].kind;
          pos_x_i    <= pending_items[0].x;
          pos_y_i    <= pending_items[0].y;
          pos_z_i    <= pending_items[0].z;
          extent_i   <= pending_items[0].ext;
          in_valid_i <= 1'b1;
          void'(pending_items.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    logic want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (visible_due.size() == 0) begin
          if (fail_count < 10) $display("unexpected item: visible %0b", visible_o);
          fail_count++;
        end else begin
          want = visible_due.pop_front();
          if (visible_o !== want) begin
            if (fail_count < 10) begin
              $display("visible: expected %0b, got %0b", want, visible_o);
            end
            fail_count++;
          end
        end
      end
      // The long hold-off lets the row fill up so that the input stalls.
      if (hold_armed && !hold_used) begin
        hold_used   <= 1'b1;
        hold_left   <= LongHold;
        out_stall_i <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left   <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // ------------------------------------------------------------------ helpers

  task automatic apb_write(input int idx, input logic [PlaneW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(idx * 8);
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx < PlaneCount) plane_reg[idx] = data;
  endtask

  function automatic logic [PlaneW-1:0] pack_plane(int nx, int ny, int nz, int d);
    return {16'(d), 16'(nz), 16'(ny), 16'(nx)};
  endfunction

  function automatic int jig(int spread);
    return int'($urandom_range(2 * spread)) - spread;
  endfunction

  // Axis-aligned box of half sizes bx, by, bz; wob tilts the normals a little.
  task automatic write_box(input int bx, input int by, input int bz, input int wob);
    apb_write(RegNear,   pack_plane(jig(wob), jig(wob), 16383 - jig(wob) - wob, bz));
    apb_write(RegFar,    pack_plane(jig(wob), jig(wob), -16384 + jig(wob) + wob, bz));
    apb_write(RegLeft,   pack_plane(16383 - jig(wob) - wob, jig(wob), jig(wob), bx));
    apb_write(RegRight,  pack_plane(-16384 + jig(wob) + wob, jig(wob), jig(wob), bx));
    apb_write(RegTop,    pack_plane(jig(wob), -16384 + jig(wob) + wob, jig(wob), by));
    apb_write(RegBottom, pack_plane(jig(wob), 16383 - jig(wob) - wob, jig(wob), by));
  endtask

  task automatic add_item(input logic [1:0] k, input int x, input int y, input int z,
                          input int e);
    fvt_item_t it;
    it.kind = k;
    it.x    = 16'(x);
    it.y    = 16'(y);
    it.z    = 16'(z);
    it.ext  = 15'(e);
    pending_items.push_back(it);
  endtask

  function automatic fvt_item_t rand_item(int span);
    fvt_item_t it;
    it.kind = ($urandom_range(99) < 6) ? KindUnused : 2'($urandom_range(2));
    if ($urandom_range(3) == 0) begin
      it.x = 16'($urandom);
      it.y = 16'($urandom);
      it.z = 16'($urandom);
    end else begin
      it.x = 16'(jig(span));
      it.y = 16'(jig(span));
      it.z = 16'(jig(span));
    end
    it.ext = $urandom_range(1) ? 15'($urandom_range(span / 2)) : 15'($urandom);
    return it;
  endfunction

  task automatic drain();
    while (pending_items.size() != 0 || in_valid_i || visible_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // ----------------------------------------------------------------- sequence

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("frustum_visibility_test_unit: mismatch");
    $finish;
  end

  initial begin
    int span, b;
    logic [PlaneW-1:0] pat [3];
    for (int k = 0; k < PlaneCount; k++) plane_reg[k] = '0;
    pat[0] = {4{16'h7FFF}};
    pat[1] = {4{16'h8000}};
    pat[2] = {4{16'hFFFF}};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    send_idle_pct = 22;
    recv_idle_pct = 49;
    // With every plane at zero each sum is zero: only spheres pass.
    add_item(KIND_POINT, 0, 0, 0, 0);
    add_item(KIND_SPHERE, 0, 0, 0, 0);
    add_item(KIND_CUBE, 5, -5, 5, 5);
    add_item(KindUnused, 0, 0, 0, 0);
    drain();

    write_box(160, 160, 160, 0);
    // Writes to the spare slots must leave the planes alone.
    apb_write(RegSpareA, {$urandom, $urandom});
    apb_write(RegSpareB, {$urandom, $urandom});
    @(negedge clk_i);
    add_item(KIND_POINT, 0, 0, 0, 32767);
    add_item(KIND_POINT, 160, 0, 0, 0);
    add_item(KIND_POINT, 159, 0, 0, 0);
    add_item(KIND_SPHERE, 200, 0, 0, 40);
    add_item(KIND_SPHERE, 201, 0, 0, 40);
    add_item(KIND_CUBE, 210, 0, 0, 60);
    add_item(KIND_CUBE, 160, 0, 0, 0);
    add_item(KIND_CUBE, 500, 500, 500, 60);
    add_item(KindUnused, 0, 0, 0, 10);
    add_item(KIND_POINT, -32768, -32768, -32768, 32767);
    add_item(KIND_SPHERE, -32768, -32768, -32768, 32767);
    add_item(KIND_CUBE, -32768, -32768, -32768, 32767);
    add_item(KIND_POINT, 32767, 32767, 32767, 0);
    add_item(KIND_SPHERE, 32767, 32767, 32767, 0);
    add_item(KIND_CUBE, 32767, 32767, 32767, 0);
    add_item(KIND_SPHERE, 0, 0, 0, 0);
    drain();

    for (int p = 0; p < RandPhases; p++) begin
      case (p % 5)
        0: begin
          b = $urandom_range(16, 8000);
          write_box(b, $urandom_range(16, 8000), $urandom_range(16, 8000), 0);
          span = 2 * b;
        end
        1: begin
          b = $urandom_range(100, 4000);
          write_box(b, b, b, 1500);
          span = 2 * b;
        end
        2: begin
          for (int k = 0; k < PlaneCount; k++) apb_write(k, {$urandom, $urandom});
          span = 16000;
        end
        3: begin
          for (int k = 0; k < PlaneCount; k++) apb_write(k, pat[(k + p) % 3]);
          span = 16000;
        end
        default: begin
          b = $urandom_range(1, 20);
          write_box(b, b, b, 0);
          span = 4 * b;
        end
      endcase
      @(negedge clk_i);
      if (p == 3) begin
        send_idle_pct = 49;
        recv_idle_pct = 22;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_armed    = 1'b1;
      end
      for (int i = 0; i < ItemsPerPhase; i++) pending_items.push_back(rand_item(span));
      drain();
    end

    if (fail_count == 0) begin
      $display("frustum_visibility_test_unit: match");
    end else begin
      $display("frustum_visibility_test_unit: mismatch");
    end
    $finish;
  end

endmodule

### frustum_visibility_test_unit.f
hdl/fvt_pkg.sv
hdl/fvt_regs.sv
hdl/fvt_cell.sv
hdl/frustum_visibility_test_unit.sv
hdl/fvt_checker.sv
bench/tb.sv
